### hw/rtl/i2cee_pkg.sv
// Shared types and constants for the I2C EEPROM master.
`default_nettype none
package i2cee_pkg;
  localparam int unsigned WaitCounterBitsDef = 24;
  localparam logic [15:0] PhaseTicksRst = 16'd5;
  localparam logic [23:0] WriteWaitRst = 24'd10000;

  localparam logic [0:0] CfgPhaseTicks = 1'b0;
  localparam logic [0:0] CfgWriteWait  = 1'b1;

  typedef enum logic [1:0] {
    OpReadSingle = 2'd0,
    OpReadSeq    = 2'd1,
    OpWrite      = 2'd2,
    OpNone       = 2'd3
  } op_e;

  typedef enum logic [15:0] {
    PhIdle  = 16'h0001, PhStart = 16'h0002, PhTxl  = 16'h0004, PhTxh  = 16'h0008,
    PhAkl   = 16'h0010, PhAkh   = 16'h0020, PhRxl  = 16'h0040, PhRxh  = 16'h0080,
    PhMkl   = 16'h0100, PhMkh   = 16'h0200, PhRsl  = 16'h0400, PhRsh  = 16'h0800,
    PhSpl   = 16'h1000, PhSph   = 16'h2000, PhSpr  = 16'h4000, PhWait = 16'h8000
  } phase_e;

  typedef enum logic [2:0] {
    RoleDevW = 3'd0, RoleAddrHi = 3'd1, RoleAddrLo = 3'd2, RoleData = 3'd3, RoleDevR = 3'd4
  } role_e;

  // One classified tick handed from the front part to the bus engine.
  typedef struct packed {
    logic       cmd;
    op_e        op;
    logic [6:0] dev;
    logic [15:0] addr;
    logic [7:0] wdata;
    logic [7:0] count;
    logic       sda;
  } tick_t;

  // Result of one tick.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       dv;
    logic [7:0] rd;
    logic       lb;
    logic       dn;
    logic       st;
  } res_t;
endpackage
`default_nettype wire

### hw/rtl/i2cee_front.sv
// Input stage: accepts ticks, decodes the command and queues them.
`default_nettype none
module i2cee_front import i2cee_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [42:0] in_data_i,
  output logic             q_valid_o,
  input  wire logic        q_ready_i,
  output tick_t            q_tick_o
);
  tick_t buf_q [2];
  logic [0:0] wr_q, rd_q;
  logic [1:0] cnt_q;
  tick_t t;
  logic push, pop;

  always_comb begin
    t.cmd   = in_data_i[0];
    t.op    = op_e'(in_data_i[2:1]);
    t.dev   = in_data_i[9:3];
    t.addr  = in_data_i[25:10];
    t.wdata = in_data_i[33:26];
    t.count = in_data_i[41:34];
    t.sda   = in_data_i[42];
    if (t.op == OpNone) t.cmd = 1'b0;
  end

  assign in_ready_o = cnt_q != 2'd2;
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign pop = q_valid_o && q_ready_i;
  assign q_tick_o = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### hw/rtl/i2cee_engine.sv
// Bus engine: per-tick I2C phase machine with registered result.
`default_nettype none
module i2cee_engine import i2cee_pkg::*; #(
  parameter int unsigned WaitCounterBits = WaitCounterBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        q_valid_i,
  output logic             q_ready_o,
  input  tick_t            q_tick_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output res_t             res_o
);
  localparam logic [WaitCounterBits-1:0] WaitMax = '1;

  logic [15:0] pticks_q;
  logic [23:0] wwait_q;
  phase_e ph_q, ph_d;
  role_e role_q, role_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] sh_q, sh_d, rem_q, rem_d;
  logic [WaitCounterBits-1:0] tc_q, tc_d;
  op_e op_q, op_d;
  logic [6:0] dev_q, dev_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0] wb_q, wb_d;
  logic nack_q, nack_d;
  res_t r, res_q;
  logic res_v_q, step;
  logic [15:0] len;
  logic hd;
  logic [WaitCounterBits-1:0] target;
  logic [3:0] bit_inc;

  assign q_ready_o = !res_v_q || res_ready_i;
  assign step = q_valid_i && q_ready_o;
  assign res_valid_o = res_v_q;
  assign res_o = res_q;
  assign len = (pticks_q == 16'd0) ? 16'd1 : pticks_q;
  assign hd = (32'(tc_q) + 32'd1) >= {16'd0, len};
  assign bit_inc = bit_q + 4'd1;

  always_comb begin
    if (WaitCounterBits >= 24) target = WaitCounterBits'(wwait_q);
    else if (wwait_q > 24'(WaitMax)) target = WaitMax;
    else target = WaitCounterBits'(wwait_q);
  end

  always_comb begin
    ph_d = ph_q; role_d = role_q; bit_d = bit_q; sh_d = sh_q; rem_d = rem_q;
    tc_d = tc_q; op_d = op_q; dev_d = dev_q; addr_d = addr_q; wb_d = wb_q;
    nack_d = nack_q;
    r = '0; r.scl = 1'b1; r.sda = 1'b1;
    if (ph_q != PhIdle && ph_q != PhWait) tc_d = hd ? '0 : tc_q + 1'b1;
    case (ph_q)
      PhIdle: begin
        if (q_tick_i.cmd) begin
          op_d = q_tick_i.op; dev_d = q_tick_i.dev; addr_d = q_tick_i.addr;
          wb_d = q_tick_i.wdata; rem_d = q_tick_i.count; nack_d = 1'b0;
          role_d = RoleDevW; tc_d = '0; ph_d = PhStart;
        end
      end
      PhStart: begin
        r.sda = 1'b0;
        if (hd) begin
          sh_d = {dev_q, role_q == RoleDevR}; bit_d = '0;
          role_d = (role_q == RoleDevR) ? RoleDevR : RoleDevW; ph_d = PhTxl;
        end
      end
      PhTxl, PhTxh: begin
        r.scl = ph_q == PhTxh; r.sda = sh_q[7];
        if (hd) begin
          if (ph_q == PhTxl) ph_d = PhTxh;
          else begin
            sh_d = {sh_q[6:0], 1'b0}; bit_d = bit_inc;
            ph_d = (bit_inc >= 4'd8) ? PhAkl : PhTxl;
          end
        end
      end
      PhAkl: begin
        r.scl = 1'b0;
        if (hd) ph_d = PhAkh;
      end
      PhAkh: begin
        if (hd) begin
          if (q_tick_i.sda) begin
            nack_d = 1'b1; ph_d = PhSpl;
          end else if (role_q == RoleDevR) begin
            rem_d = (op_q == OpReadSeq) ? rem_q : 8'd1;
            if (rem_d == 8'd0) ph_d = PhSpl;
            else begin sh_d = '0; bit_d = '0; ph_d = PhRxl; end
          end else begin
            bit_d = '0; ph_d = PhTxl;
            case (role_q)
              RoleDevW: begin
                if (op_q == OpReadSeq || addr_q <= 16'd255) begin
                  sh_d = addr_q[7:0]; role_d = RoleAddrLo;
                end else begin
                  sh_d = addr_q[15:8]; role_d = RoleAddrHi;
                end
              end
              RoleAddrHi: begin sh_d = addr_q[7:0]; role_d = RoleAddrLo; end
              RoleAddrLo: begin
                if (op_q == OpWrite) begin sh_d = wb_q; role_d = RoleData; end
                else begin role_d = RoleDevR; ph_d = PhRsl; bit_d = bit_q; end
              end
              default: begin ph_d = PhSpl; bit_d = bit_q; end
            endcase
          end
        end
      end
      PhRxl: begin
        r.scl = 1'b0;
        if (hd) ph_d = PhRxh;
      end
      PhRxh: begin
        if (hd) begin
          sh_d = {sh_q[6:0], q_tick_i.sda}; bit_d = bit_inc;
          if (bit_inc >= 4'd8) begin
            r.dv = 1'b1; r.rd = sh_d; r.lb = rem_q <= 8'd1; ph_d = PhMkl;
          end else ph_d = PhRxl;
        end
      end
      PhMkl, PhMkh: begin
        r.scl = ph_q == PhMkh; r.sda = rem_q <= 8'd1;
        if (hd) begin
          if (ph_q == PhMkl) ph_d = PhMkh;
          else begin
            if (rem_q != 8'd0) rem_d = rem_q - 8'd1;
            if (rem_d == 8'd0) ph_d = PhSpl;
            else begin sh_d = '0; bit_d = '0; ph_d = PhRxl; end
          end
        end
      end
      PhRsl: begin
        r.scl = 1'b0;
        if (hd) ph_d = PhRsh;
      end
      PhRsh: if (hd) ph_d = PhStart;
      PhSpl: begin
        r.scl = 1'b0; r.sda = 1'b0;
        if (hd) ph_d = PhSph;
      end
      PhSph: begin
        r.sda = 1'b0;
        if (hd) ph_d = PhSpr;
      end
      PhSpr: begin
        if (hd) begin
          if (!nack_q && op_q == OpWrite && wwait_q != 24'd0) begin
            tc_d = '0; ph_d = PhWait;
          end else begin
            r.dn = 1'b1; r.st = nack_q; ph_d = PhIdle;
          end
        end
      end
      PhWait: begin
        if (tc_q + 1'b1 >= target || target == '0 || tc_q == WaitMax) begin
          tc_d = '0; r.dn = 1'b1; ph_d = PhIdle;
        end else tc_d = tc_q + 1'b1;
      end
      default: ph_d = PhIdle;
    endcase
    r.busy = ph_d != PhIdle;
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pticks_q <= PhaseTicksRst; wwait_q <= WriteWaitRst;
      ph_q <= PhIdle; role_q <= RoleDevW; bit_q <= '0; sh_q <= '0; rem_q <= '0;
      tc_q <= '0; op_q <= OpReadSingle; dev_q <= '0; addr_q <= '0; wb_q <= '0;
      nack_q <= 1'b0; res_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_idx_i == CfgPhaseTicks) pticks_q <= cfg_data_i[15:0];
        else wwait_q <= cfg_data_i;
      end
      if (step) begin
        ph_q <= ph_d; role_q <= role_d; bit_q <= bit_d; sh_q <= sh_d; rem_q <= rem_d;
        tc_q <= tc_d; op_q <= op_d; dev_q <= dev_d; addr_q <= addr_d; wb_q <= wb_d;
        nack_q <= nack_d;
      end
      if (step) res_v_q <= 1'b1;
      else if (res_ready_i) res_v_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/i2c_eeprom_master.sv
// Top level of the tick-driven I2C EEPROM master.
// Each input item is one timebase tick (optional command plus sampled SDA) and yields
// exactly one result item (SCL/SDA drive and status). One item per clock is sustained
// unless the output stalls: a two-entry queue feeds the bus engine, whose phase
// machine does one tick of work per cycle into an output register. Configuration is
// to be written by the user only while no transaction is in progress; the block does
// not enforce it. Register 0 is ticks per SCL half phase, register 1 the post-write wait.
`default_nettype none
module i2c_eeprom_master import i2cee_pkg::*; #(
  parameter int unsigned WaitCounterBits = WaitCounterBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // cmd_valid, operation[2], device_addr[7], mem_addr[16], write_data[8],
  // byte_count[8], sda_in, zero pad
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // scl_out, sda_out, busy_res, data_valid, read_data[8], last_byte,
  // done_res, status, zero pad
  output logic [15:0]      m_axis_tdata
);
  logic q_valid, q_ready;
  tick_t q_tick;
  res_t res;

  assign cfg_ready_o = 1'b1;

  i2cee_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata[42:0]),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_tick_o   (q_tick)
  );

  i2cee_engine #(.WaitCounterBits(WaitCounterBits)) u_engine (
    .clk_i, .rst_ni,
    .cfg_valid_i (cfg_valid_i),
    .cfg_idx_i   (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_tick_i    (q_tick),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {1'b0, res.st, res.dn, res.lb, res.rd, res.dv, res.busy,
                         res.sda, res.scl};
endmodule
`default_nettype wire

### dv/i2cee_checker.sv
// Tick predictor and result comparator for the I2C EEPROM master.
`timescale 1ns / 100ps
module i2cee_checker import i2cee_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [47:0] s_tdata_i,
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [15:0] m_tdata_i,
  output int               errors_o,
  output int               pending_o,
  output logic             bus_idle_o
);
  logic [15:0] half_ticks;
  logic [23:0] wr_wait;

  phase_e      ph;
  role_e       byte_role;
  op_e         h_op;
  logic [6:0]  h_dev;
  logic [15:0] h_addr;
  logic [7:0]  h_wdata;
  logic [7:0]  shreg;
  logic [3:0]  bitn;
  logic [7:0]  remaining;
  logic [23:0] tcnt;
  logic        nack;

  logic [15:0] bus_results[$];

  // end of an SCL half phase; restarts the tick count
  function automatic logic half_done();
    int unsigned len;
    len = (half_ticks == 0) ? 1 : half_ticks;
    if (tcnt + 1 >= len) begin
      tcnt = '0;
      return 1'b1;
    end
    tcnt = tcnt + 1;
    return 1'b0;
  endfunction

  function automatic void load_byte(logic [7:0] b, role_e r);
    shreg = b;
    bitn = '0;
    byte_role = r;
    ph = PhTxl;
  endfunction

  function automatic void start_rx();
    shreg = '0;
    bitn = '0;
    ph = PhRxl;
  endfunction

  function automatic logic [15:0] bus_tick(logic [47:0] d);
    logic scl, sda, dv, lb, dn, st, sda_in;
    logic [7:0] rd;
    int unsigned lim;
    scl = 1'b1; sda = 1'b1; dv = 0; lb = 0; dn = 0; st = 0; rd = '0;
    sda_in = d[42];
    case (ph)
      PhIdle: begin
        if (d[0] && op_e'(d[2:1]) != OpNone) begin
          h_op = op_e'(d[2:1]);
          h_dev = d[9:3];
          h_addr = d[25:10];
          h_wdata = d[33:26];
          remaining = d[41:34];
          nack = 1'b0;
          byte_role = RoleDevW;
          tcnt = '0;
          ph = PhStart;
        end
      end
      PhStart: begin
        sda = 1'b0;
        if (half_done()) begin
          load_byte({h_dev, byte_role == RoleDevR},
                    (byte_role == RoleDevR) ? RoleDevR : RoleDevW);
        end
      end
      PhTxl, PhTxh: begin
        scl = (ph == PhTxh);
        sda = shreg[7];
        if (half_done()) begin
          if (ph == PhTxl) begin
            ph = PhTxh;
          end else begin
            shreg = {shreg[6:0], 1'b0};
            bitn = bitn + 1;
            ph = (bitn >= 8) ? PhAkl : PhTxl;
          end
        end
      end
      PhAkl: begin
        scl = 1'b0;
        if (half_done()) ph = PhAkh;
      end
      PhAkh: begin
        if (half_done()) begin
          if (sda_in) begin
            nack = 1'b1;
            ph = PhSpl;
          end else if (byte_role == RoleDevR) begin
            if (h_op != OpReadSeq) remaining = 8'd1;
            if (remaining == 0) ph = PhSpl;
            else start_rx();
          end else begin
            case (byte_role)
              RoleDevW: begin
                if (h_op == OpReadSeq || h_addr <= 16'd255) load_byte(h_addr[7:0], RoleAddrLo);
                else load_byte(h_addr[15:8], RoleAddrHi);
              end
              RoleAddrHi: load_byte(h_addr[7:0], RoleAddrLo);
              RoleAddrLo: begin
                if (h_op == OpWrite) begin
                  load_byte(h_wdata, RoleData);
                end else begin
                  byte_role = RoleDevR;
                  ph = PhRsl;
                end
              end
              default: ph = PhSpl;
            endcase
          end
        end
      end
      PhRxl: begin
        scl = 1'b0;
        if (half_done()) ph = PhRxh;
      end
      PhRxh: begin
        if (half_done()) begin
          shreg = {shreg[6:0], sda_in};
          bitn = bitn + 1;
          if (bitn >= 8) begin
            dv = 1'b1;
            rd = shreg;
            lb = (remaining <= 1);
            ph = PhMkl;
          end else begin
            ph = PhRxl;
          end
        end
      end
      PhMkl, PhMkh: begin
        scl = (ph == PhMkh);
        sda = (remaining <= 1);
        if (half_done()) begin
          if (ph == PhMkl) begin
            ph = PhMkh;
          end else begin
            if (remaining > 0) remaining = remaining - 1;
            if (remaining == 0) ph = PhSpl;
            else start_rx();
          end
        end
      end
      PhRsl: begin
        scl = 1'b0;
        if (half_done()) ph = PhRsh;
      end
      PhRsh: if (half_done()) ph = PhStart;
      PhSpl: begin
        scl = 1'b0;
        sda = 1'b0;
        if (half_done()) ph = PhSph;
      end
      PhSph: begin
        sda = 1'b0;
        if (half_done()) ph = PhSpr;
      end
      PhSpr: begin
        if (half_done()) begin
          if (!nack && h_op == OpWrite && wr_wait != 0) begin
            tcnt = '0;
            ph = PhWait;
          end else begin
            dn = 1'b1;
            st = nack;
            ph = PhIdle;
          end
        end
      end
      default: begin
        lim = wr_wait;
        if (tcnt + 1 >= lim || lim == 0) begin
          tcnt = '0;
          dn = 1'b1;
          ph = PhIdle;
        end else begin
          tcnt = tcnt + 1;
        end
      end
    endcase
    return {1'b0, st, dn, lb, rd, dv, ph != PhIdle, sda, scl};
  endfunction

  function automatic void cmp(string nm, int unsigned e, int unsigned a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, nm, e, a);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    if (!rst_ni) begin
      half_ticks = PhaseTicksRst;
      wr_wait = WriteWaitRst;
      ph = PhIdle;
      byte_role = RoleDevW;
      h_op = OpReadSingle;
      h_dev = '0; h_addr = '0; h_wdata = '0;
      shreg = '0; bitn = '0; remaining = '0; tcnt = '0; nack = 1'b0;
      bus_results.delete();
      errors_o <= 0;
      pending_o <= 0;
      bus_idle_o <= 1'b1;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgPhaseTicks: half_ticks = cfg_data_i[15:0];
          CfgWriteWait:  wr_wait = cfg_data_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (bus_results.size() == 0) begin
          $display("%0t unexpected result: expected none actual %0h", $time, m_tdata_i);
          errors_o++;
        end else begin
          want = bus_results.pop_front();
          cmp("scl", want[0], m_tdata_i[0]);
          cmp("sda", want[1], m_tdata_i[1]);
          cmp("busy", want[2], m_tdata_i[2]);
          cmp("data_valid", want[3], m_tdata_i[3]);
          cmp("read_data", want[11:4], m_tdata_i[11:4]);
          cmp("last_byte", want[12], m_tdata_i[12]);
          cmp("done", want[13], m_tdata_i[13]);
          cmp("status", want[14], m_tdata_i[14]);
          cmp("pad", want[15], m_tdata_i[15]);
        end
      end
      if (s_tvalid_i && s_tready_i) bus_results.push_back(bus_tick(s_tdata_i));
      pending_o <= bus_results.size();
      bus_idle_o <= (ph == PhIdle);
    end
  end
endmodule

### dv/tb_top.sv
// Testbench top: tick stimulus, configuration phases and the verdict.
`timescale 1ns / 100ps
module tb_top;
  import i2cee_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [15:0] m_tdata;
  int          errors, pending;
  logic        bus_idle;
  logic        quiet = 1'b0;
  int          n_ticks = 0;

  always #5 clk_i = ~clk_i;

  i2c_eeprom_master u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata)
  );

  i2cee_checker u_chk (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .errors_o(errors), .pending_o(pending), .bus_idle_o(bus_idle)
  );

  function automatic logic [47:0] tick_word(logic cmd, op_e op, logic [6:0] dev,
      logic [15:0] addr, logic [7:0] wd, logic [7:0] cnt, logic sda);
    return {5'b0, sda, cnt, wd, addr, dev, op, cmd};
  endfunction

  task automatic send_tick(input logic [47:0] d);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    n_ticks++;
  endtask

  // SDA modes: 0 device mostly acknowledges, 1 line stuck high, 2 random
  function automatic logic sda_level(int mode);
    if (mode == 1) return 1'b1;
    if (mode == 2) return 1'($urandom_range(0, 1));
    return $urandom_range(0, 99) < 4;
  endfunction

  task automatic run_txn(input op_e op, input logic [6:0] dev, input logic [15:0] addr,
      input logic [7:0] wd, input logic [7:0] cnt, input int mode);
    send_tick(tick_word(1'b1, op, dev, addr, wd, cnt, sda_level(mode)));
    if (op == OpNone) return;
    do begin
      // commands while busy must be ignored
      send_tick(tick_word($urandom_range(0, 9) == 0, op_e'($urandom_range(0, 3)),
                          7'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                          sda_level(mode)));
    end while (!bus_idle);
  endtask

  task automatic settle();
    // idle ticks until any transaction a stray command started has ended
    do begin
      send_tick(tick_word(1'b0, OpReadSingle, '0, '0, '0, '0, 1'($urandom_range(0, 1))));
    end while (!bus_idle);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 11) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [15:0] addr;
    logic [7:0]  cnt;
    int          pick, mode;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timing first
    run_txn(OpReadSingle, 7'h50, 16'h0012, 8'h00, 8'h00, 0);
    settle();
    write_reg(CfgPhaseTicks, 24'd1);
    write_reg(CfgWriteWait, 24'd3);
    run_txn(OpReadSingle, 7'h00, 16'h0000, 8'h00, 8'h00, 0);
    run_txn(OpReadSingle, 7'h7f, 16'hffff, 8'hff, 8'hff, 2);
    run_txn(OpReadSingle, 7'h2a, 16'h00ff, 8'h00, 8'h00, 0);
    run_txn(OpReadSingle, 7'h55, 16'h0100, 8'h00, 8'h00, 0);
    run_txn(OpReadSeq, 7'h50, 16'h1234, 8'h00, 8'h00, 0);
    run_txn(OpReadSeq, 7'h50, 16'hffff, 8'h00, 8'h03, 2);
    run_txn(OpReadSeq, 7'h51, 16'h00a5, 8'h00, 8'h05, 0);
    run_txn(OpWrite, 7'h50, 16'h1234, 8'hff, 8'h00, 0);
    run_txn(OpWrite, 7'h50, 16'h0000, 8'h00, 8'h00, 0);
    run_txn(OpNone, 7'h50, 16'h0010, 8'h5a, 8'h02, 0);
    run_txn(OpWrite, 7'h33, 16'h0400, 8'ha5, 8'h00, 1);
    run_txn(OpReadSingle, 7'h33, 16'h0400, 8'h00, 8'h00, 1);
    settle();
    write_reg(CfgWriteWait, 24'd0);
    run_txn(OpWrite, 7'h50, 16'h0042, 8'h3c, 8'h00, 0);
    settle();
    write_reg(CfgPhaseTicks, 24'd0);
    run_txn(OpReadSeq, 7'h50, 16'h0042, 8'h00, 8'h02, 0);
    settle();
    // largest settings, exercised only by idle ticks
    write_reg(CfgPhaseTicks, 24'd65535);
    write_reg(CfgWriteWait, 24'hffffff);
    repeat (3) send_tick(tick_word(1'b0, OpReadSingle, '0, '0, '0, '0, 1'b1));
    settle();
    write_reg(CfgPhaseTicks, 24'd2);
    write_reg(CfgWriteWait, 24'd7);

    while (n_ticks < 1450) begin
      if (n_ticks > 1250) quiet = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        settle();
        write_reg(CfgPhaseTicks, 24'($urandom_range(1, 3)));
        write_reg(CfgWriteWait, 24'($urandom_range(0, 30)));
      end
      repeat ($urandom_range(0, 3))
        send_tick(tick_word(1'b0, op_e'($urandom_range(0, 3)), 7'($urandom),
                            16'($urandom), 8'($urandom), 8'($urandom),
                            1'($urandom_range(0, 1))));
      addr = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 255)) : 16'($urandom);
      cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 12)) : 8'($urandom_range(0, 4));
      pick = $urandom_range(0, 9);
      mode = (pick < 7) ? 0 : (pick < 9) ? 2 : 1;
      run_txn(op_e'($urandom_range(0, 3)), 7'($urandom), addr, 8'($urandom), cnt, mode);
    end

    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
